@@ sv/grws_pkg.sv @@
// ----------------------------------------------------------------------------
// grws_pkg: shared types and constants of the random walk sampler
// Beat layouts, graph sizing, generator taps and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package grws_pkg;

   localparam int NODES       = 1024;
   localparam int MAX_DEGREE  = 16;
   localparam int MAX_HOPS    = 16;

   localparam int NODE_W      = 10;
   localparam int CNT_W       = $clog2(MAX_DEGREE + 1);
   localparam int PICK_W      = $clog2(MAX_DEGREE);
   localparam int HOP_W       = 5;
   localparam int SEED_W      = 32;
   localparam int TBL_AW      = NODE_W + PICK_W;

   localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

   // remainder unit: bits of the dividend folded in per cycle
   localparam int MOD_BITS    = 8;
   localparam int MOD_STEPS   = SEED_W / MOD_BITS;
   localparam int MOD_STEP_W  = $clog2(MOD_STEPS);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_WALK = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] neighbor;
      logic [HOP_W-1:0]  walk_length;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] start_node;
      logic [NODE_W-1:0] end_node;
      logic              dead_end;
   } rsp_type;

   typedef struct packed {
      logic clr_step;   // clear one count entry and advance the sweep
      logic capture;    // take the accepted request beat
      logic cnt_rd;     // read the count of the current node
      logic cnt_wr;     // append the neighbour to the current node
      logic mark_dead;  // stop the walk at the current node
      logic hop_go;     // advance the generator and start the remainder
      logic tbl_rd;     // read the chosen neighbour
      logic hop_next;   // move to the neighbour, count the hop
      logic post;       // load the response register
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_kind;
      logic hops_zero;
      logic cnt_full;
      logic cnt_bad;
      logic mod_done;
      logic out_free;
   } sts_type;

endpackage

@@ sv/graph_random_walk_sampler_top.sv @@
// ----------------------------------------------------------------------------
// graph_random_walk_sampler_top: uniform random walk sampler
// Stores up to sixteen neighbours for each of 1024 nodes and walks the graph
// from a given start node, picking neighbours with a 32-bit Galois LFSR.
// ----------------------------------------------------------------------------
// Use:
//   req_*  request beats. kind 0 appends neighbor to node's list (dropped
//          once the list holds sixteen entries, no response). kind 1 walks
//          walk_length hops (saturated at sixteen) from node.
//   rsp_*  one response beat per walk: start node, end node, dead-end flag.
//          A walk stops early at a node without neighbours.
//   csr_*  seed write; loads the generator at once, zero is taken as one.
//          Always ready; write only while the block is idle.
// Timing: one item at a time. An append is a count read and then a count
//   write before ready returns. A walk posts its response after its hops;
//   each hop is a count read, a remainder unit (8 dividend bits a cycle) and a
//   neighbour table read, all through single-port registered memories.
// Reset: the generator reloads with one, and a sweep over all 1024 nodes
//   clears the neighbour counts, with req_ready low throughout.
// Stall: a finished response waits in the output register; appends are still
//   taken, and a following walk holds in its last state until rsp_ready.
// ----------------------------------------------------------------------------
module graph_random_walk_sampler_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  grws_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output grws_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [grws_pkg::SEED_W-1:0]  csr_data
);
   import grws_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // the seed register is taken in any cycle
   assign csr_ready = 1'b1;

   // sequencing: clearing sweep, append steps and the hop loop
   grws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, generator, remainder unit and response register
   grws_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // never overwrite a response beat that is still waiting
   a_post_free: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> sts.out_free)
      else $error("response register overwritten while held");

   // never append past a full neighbour list
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_wr |-> !sts.cnt_full)
      else $error("append into a full list");

   // no request beat taken while the count sweep runs
   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_ready)
      else $error("request accepted during clearing sweep");

   // remainder completion is a single-cycle pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      sts.mod_done |=> !sts.mod_done)
      else $error("remainder done held for more than one cycle");
`endif

endmodule

@@ sv/grws_mod.sv @@
// ----------------------------------------------------------------------------
// grws_mod: iterative remainder unit
// Reduces a 32-bit value modulo a small neighbour count, several dividend
// bits per cycle, by restoring shift and subtract.
// ----------------------------------------------------------------------------
module grws_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [grws_pkg::SEED_W-1:0]  dividend,
   input  logic [grws_pkg::CNT_W-1:0]   divisor,
   output logic                         done,
   output logic [grws_pkg::PICK_W-1:0]  rem
);
   import grws_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic [SEED_W-1:0]     dvd_ff, dvd_in;
   logic [CNT_W-1:0]      dvs_ff, dvs_in;
   logic [PICK_W-1:0]     rem_ff, rem_in;
   logic [PICK_W-1:0]     rem_next;

   always_comb begin
      logic [PICK_W-1:0] r;
      logic [CNT_W-1:0]  t;
      r = rem_ff;
      t = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         t = {r, dvd_ff[SEED_W-1-i]};
         if (t >= dvs_ff) begin
            t = t - dvs_ff;
         end
         r = t[PICK_W-1:0];
      end
      rem_next = r;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_next;
         dvd_in  = dvd_ff << MOD_BITS;
         step_in = step_ff + 1'b1;
         if (step_ff == MOD_STEP_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ sv/grws_datapath.sv @@
// ----------------------------------------------------------------------------
// grws_datapath: adjacency store, generator and walk registers
// Holds the count and neighbour memories, the Galois generator, the walk
// position and the response register; acts on controller commands.
// ----------------------------------------------------------------------------
module grws_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  grws_pkg::req_type            req_data,
   input  logic                         csr_write,
   input  logic [grws_pkg::SEED_W-1:0]  csr_data,
   input  grws_pkg::cmd_type            cmd,
   output grws_pkg::sts_type            sts,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output grws_pkg::rsp_type            rsp_data
);
   import grws_pkg::*;

   logic [CNT_W-1:0]  cnt_mem [NODES];
   logic [NODE_W-1:0] tbl_mem [NODES*MAX_DEGREE];

   logic [NODE_W-1:0] clr_addr_ff;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] start_ff, start_in;
   logic [NODE_W-1:0] nb_ff, nb_in;
   logic [HOP_W-1:0]  hops_ff, hops_in;
   logic              dead_ff, dead_in;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic [NODE_W-1:0] tbl_rd_ff;
   logic [SEED_W-1:0] lfsr_ff, lfsr_in, lfsr_next;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic              mod_done;
   logic [PICK_W-1:0] mod_rem;

   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   always_comb begin
      lfsr_in = lfsr_ff;
      if (csr_write) begin
         lfsr_in = (csr_data == '0) ? SEED_W'(1) : csr_data;
      end else if (cmd.hop_go) begin
         lfsr_in = lfsr_next;
      end
   end

   always_comb begin
      cur_in   = cur_ff;
      start_in = start_ff;
      nb_in    = nb_ff;
      hops_in  = hops_ff;
      dead_in  = dead_ff;
      if (cmd.capture) begin
         cur_in   = req_data.node;
         start_in = req_data.node;
         nb_in    = req_data.neighbor;
         hops_in  = (req_data.walk_length > HOP_W'(MAX_HOPS)) ? HOP_W'(MAX_HOPS)
                                                              : req_data.walk_length;
         dead_in  = 1'b0;
      end
      if (cmd.mark_dead) begin
         dead_in = 1'b1;
      end
      if (cmd.hop_next) begin
         cur_in  = tbl_rd_ff;
         hops_in = hops_ff - 1'b1;
      end
   end

   grws_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.hop_go),
      .dividend (lfsr_next),
      .divisor  (cnt_rd_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   // count memory: one write port shared by the clearing sweep and appends
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         cnt_mem[clr_addr_ff] <= '0;
      end else if (cmd.cnt_wr) begin
         cnt_mem[cur_ff] <= cnt_rd_ff + 1'b1;
      end
      if (cmd.cnt_rd) begin
         cnt_rd_ff <= cnt_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_wr) begin
         tbl_mem[{cur_ff, cnt_rd_ff[PICK_W-1:0]}] <= nb_ff;
      end
      if (cmd.tbl_rd) begin
         tbl_rd_ff <= tbl_mem[{cur_ff, mod_rem}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         lfsr_ff      <= SEED_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         lfsr_ff <= lfsr_in;
         if (cmd.post) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      start_ff <= start_in;
      nb_ff    <= nb_in;
      hops_ff  <= hops_in;
      dead_ff  <= dead_in;
      if (cmd.post) begin
         rsp_ff.start_node <= start_ff;
         rsp_ff.end_node   <= cur_ff;
         rsp_ff.dead_end   <= dead_ff;
      end
   end

   always_comb begin
      sts.clr_last  = (clr_addr_ff == NODE_W'(NODES - 1));
      sts.req_kind  = req_data.kind;
      sts.hops_zero = (hops_ff == '0);
      sts.cnt_full  = (cnt_rd_ff >= CNT_W'(MAX_DEGREE));
      sts.cnt_bad   = (cnt_rd_ff == '0) || (cnt_rd_ff > CNT_W'(MAX_DEGREE));
      sts.mod_done  = mod_done;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/grws_ctrl.sv @@
// ----------------------------------------------------------------------------
// grws_ctrl: sequencing state machine
// Runs the count clearing sweep, the append sequence and the hop loop of a
// walk, issuing one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module grws_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grws_pkg::sts_type sts,
   output grws_pkg::cmd_type cmd
);
   import grws_pkg::*;

   typedef enum logic [9:0] {
      ST_CLEAR    = 10'b00_0000_0001,
      ST_IDLE     = 10'b00_0000_0010,
      ST_LOAD_RD  = 10'b00_0000_0100,
      ST_LOAD_WR  = 10'b00_0000_1000,
      ST_HOP_RD   = 10'b00_0001_0000,
      ST_HOP_CHK  = 10'b00_0010_0000,
      ST_MOD      = 10'b00_0100_0000,
      ST_TBL_RD   = 10'b00_1000_0000,
      ST_HOP_NEXT = 10'b01_0000_0000,
      ST_FINISH   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = (sts.req_kind == KIND_WALK) ? ST_HOP_RD : ST_LOAD_RD;
            end
         end
         ST_LOAD_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            cmd.cnt_wr = !sts.cnt_full;
            state_in   = ST_IDLE;
         end
         ST_HOP_RD: begin
            if (sts.hops_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.cnt_rd = 1'b1;
               state_in   = ST_HOP_CHK;
            end
         end
         ST_HOP_CHK: begin
            if (sts.cnt_bad) begin
               cmd.mark_dead = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.hop_go = 1'b1;
               state_in   = ST_MOD;
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_TBL_RD;
            end
         end
         ST_TBL_RD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = ST_HOP_NEXT;
         end
         ST_HOP_NEXT: begin
            cmd.hop_next = 1'b1;
            state_in     = ST_HOP_RD;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
